>>> rtl/mmp2_pkg.sv
// Package for the 2x2 modular matrix power block.
// Holds widths, the sequencer state type and the identity constant; no dependencies.
package mmp2_pkg;
  localparam int unsigned EntryWidth = 16;
  localparam int unsigned PowerWidth = 31;
  localparam int unsigned ProdWidth  = 2 * EntryWidth;
  localparam int unsigned RemWidth   = EntryWidth + 1;
  localparam int unsigned DivCntW    = $clog2(ProdWidth + 1);

  typedef logic [EntryWidth-1:0] entry_t;
  typedef entry_t [3:0] mat_t;

  localparam mat_t Identity = '{entry_t'(1), entry_t'(0), entry_t'(0), entry_t'(1)};

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StMul   = 7'b0000010,
    StDiv   = 7'b0000100,
    StAcc   = 7'b0001000,
    StNext  = 7'b0010000,
    StRound = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;
endpackage

>>> rtl/modular_matrix_power_2x2_top.sv
// Top level of the 2x2 modular matrix power block (right-to-left square and multiply).
// Depends on mmp2_pkg; one shared 16x16 multiplier and one bit-serial remainder unit.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | entry_* (4x16), power (31), modulus (16)
//  out     | output    | out_valid/out_ready| result_* (4x16)
//
// Each item is first reduced (4 remainders, each: load, 32 shift steps, store, advance),
// then per exponent bit up to two matrix products of 8 products+remainders each plus a
// commit step; the remainder unit sets the pace. A zero exponent or zero modulus skips
// the arithmetic and goes straight to the result.
// One item at a time: in_ready is low from accept until the result is taken.
// The result holds while out_ready is low. Reset clears control state only.
module modular_matrix_power_2x2_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] entry_top_left_i,
  input  logic [15:0] entry_top_right_i,
  input  logic [15:0] entry_bottom_left_i,
  input  logic [15:0] entry_bottom_right_i,
  input  logic [30:0] power_i,
  input  logic [15:0] modulus_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] result_top_left_o,
  output logic [15:0] result_top_right_o,
  output logic [15:0] result_bottom_left_o,
  output logic [15:0] result_bottom_right_o
);
  localparam int unsigned EW = mmp2_pkg::EntryWidth;
  localparam int unsigned PW = mmp2_pkg::ProdWidth;
  localparam int unsigned RW = mmp2_pkg::RemWidth;
  localparam int unsigned CW = mmp2_pkg::DivCntW;

  mmp2_pkg::state_e state_q, state_d;
  mmp2_pkg::mat_t acc_q, acc_d, base_q, base_d, res_q, res_d;
  logic [mmp2_pkg::PowerWidth-1:0] pow_q, pow_d;
  mmp2_pkg::entry_t md_q, md_d;
  // phase: 0 = initial reduce, 1 = acc*base, 2 = base*base
  logic [1:0] phase_q, phase_d;
  logic [2:0] step_q, step_d;       // product index within a matrix product
  logic [PW-1:0] dvd_q, dvd_d;      // dividend shifted out MSB first
  logic [RW-1:0] rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  mmp2_pkg::entry_t part_q, part_d; // first reduced product of a pair

  // operand select for the shared multiplier
  mmp2_pkg::entry_t opa, opb, lhs_a, lhs_b;
  logic [1:0] row, col, k;
  logic [RW-1:0] rtry, rsum, rred;
  logic [RW-1:0] rsh;

  always_comb begin
    row = {1'b0, step_q[2]};
    col = {1'b0, step_q[1]};
    k   = {1'b0, step_q[0]};
    lhs_a = (phase_q == 2'd1) ? acc_q[3 - (row * 2 + k)] : base_q[3 - (row * 2 + k)];
    lhs_b = base_q[3 - (k * 2 + col)];
    opa = lhs_a;
    opb = lhs_b;
  end

  // remainder step: shift in one dividend bit, subtract if possible
  always_comb begin
    rsh  = {rem_q[RW-2:0], dvd_q[PW-1]};
    rtry = rsh - {1'b0, md_q};
    // reduce pair sum: part + rem, both below md, so one compare and subtract
    rsum = {1'b0, part_q} + rem_q;
    rred = (rsum >= {1'b0, md_q}) ? rsum - {1'b0, md_q} : rsum;
  end

  always_comb begin
    state_d = state_q;
    acc_d = acc_q; base_d = base_q; res_d = res_q;
    pow_d = pow_q; md_d = md_q; phase_d = phase_q; step_d = step_q;
    dvd_d = dvd_q; rem_d = rem_q; cnt_d = cnt_q; part_d = part_q;
    unique case (state_q)
      mmp2_pkg::StIdle: begin
        if (in_valid_i) begin
          pow_d = power_i;
          md_d  = modulus_i;
          base_d = '{entry_top_left_i, entry_top_right_i,
                     entry_bottom_left_i, entry_bottom_right_i};
          acc_d = mmp2_pkg::Identity;
          if (power_i == '0) begin
            res_d = mmp2_pkg::Identity;
            state_d = mmp2_pkg::StOut;
          end else if (modulus_i == '0) begin
            res_d = '0;
            state_d = mmp2_pkg::StOut;
          end else begin
            phase_d = 2'd0;
            step_d = '0;
            state_d = mmp2_pkg::StMul;
          end
        end
      end
      mmp2_pkg::StMul: begin
        if (phase_q == 2'd0) dvd_d = {base_q[3 - step_q[1:0]], {EW{1'b0}}} >> EW;
        else dvd_d = opa * opb;
        rem_d = '0;
        cnt_d = CW'(PW);
        state_d = mmp2_pkg::StDiv;
      end
      mmp2_pkg::StDiv: begin
        dvd_d = {dvd_q[PW-2:0], 1'b0};
        rem_d = rtry[RW-1] ? rsh : rtry;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) state_d = mmp2_pkg::StAcc;
      end
      mmp2_pkg::StAcc: begin
        state_d = mmp2_pkg::StNext;
        if (phase_q == 2'd0) begin
          base_d[3 - step_q[1:0]] = rem_q[EW-1:0];
          step_d = step_q + 3'd1;
          if (step_q == 3'd3) begin
            step_d = '0;
            phase_d = pow_q[0] ? 2'd1 : 2'd2;
          end
        end else if (!step_q[0]) begin
          part_d = rem_q[EW-1:0];
          step_d = step_q + 3'd1;
        end else begin
          res_d[3 - {step_q[2], step_q[1]}] = rred[EW-1:0];
          step_d = step_q + 3'd1;
          if (step_q == 3'd7) state_d = mmp2_pkg::StRound;
        end
      end
      mmp2_pkg::StNext: state_d = mmp2_pkg::StMul;
      mmp2_pkg::StRound: begin
        step_d = '0;
        state_d = mmp2_pkg::StMul;
        if (phase_q == 2'd1) begin
          acc_d = res_q;
          phase_d = 2'd2;
        end else begin
          base_d = res_q;
          pow_d = pow_q >> 1;
          if (pow_q[mmp2_pkg::PowerWidth-1:1] == '0) begin
            res_d = acc_q;
            state_d = mmp2_pkg::StOut;
          end else begin
            phase_d = pow_q[1] ? 2'd1 : 2'd2;
          end
        end
      end
      mmp2_pkg::StOut: begin
        if (out_ready_i) state_d = mmp2_pkg::StIdle;
      end
      default: state_d = mmp2_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmp2_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; base_q <= base_d; res_q <= res_d; pow_q <= pow_d; md_q <= md_d;
    phase_q <= phase_d; step_q <= step_d; dvd_q <= dvd_d; rem_q <= rem_d;
    cnt_q <= cnt_d; part_q <= part_d;
  end

  assign in_ready_o  = (state_q == mmp2_pkg::StIdle);
  assign out_valid_o = (state_q == mmp2_pkg::StOut);
  assign result_top_left_o     = res_q[3];
  assign result_top_right_o    = res_q[2];
  assign result_bottom_left_o  = res_q[1];
  assign result_bottom_right_o = res_q[0];

  // remainder always below modulus once a division ends
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mmp2_pkg::StAcc |-> rem_q < {1'b0, md_q})
    else $error("remainder out of range");
  a_ready_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mmp2_pkg::StMul |=> state_q == mmp2_pkg::StDiv && cnt_q == CW'(PW))
    else $error("division not started");
endmodule
